/* rtl/afpc_pkg.sv */
// shared constants for the aux frame parser and checker
package afpc_pkg;

	localparam logic [7:0] SYNC_BYTE_RESET = 8'h3b;
	localparam logic [7:0] MIN_LENGTH      = 8'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_LEN_ERR  = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

endpackage

/* rtl/aux_frame_parser_checker.sv */
// aux frame parser and checker: sync hunt, header capture, payload pass-through, checksum
// a request waits in the input register; any result then loads the result register
// throughput: one request per cycle if not stalled; per byte, one 8-bit add and compare
// a stalled result holds the input register, and intake stops once that register is full
// reset: asynchronous, active low; hunts for sync, sync byte back to 0x3b, no result pending
module aux_frame_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  source_id,
	output logic [7:0]  dest_id,
	output logic [7:0]  command_code,
	output logic [7:0]  payload_count,
	output logic [1:0]  status,
	output logic [23:0] position,
	output logic        position_valid
);
	import afpc_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_SRC,
		PH_DST,
		PH_CMD,
		PH_PAY,
		PH_CKS
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sync_q;
	logic [7:0]  length_q, length_d;
	logic [7:0]  seen_q, seen_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  src_q, src_d;
	logic [7:0]  dst_q, dst_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [23:0] last3_q, last3_d;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        fire;

	logic        res;
	logic        r_kind;
	logic [7:0]  r_pay, r_src, r_dst, r_cmd, r_cnt;
	logic [1:0]  r_status;
	logic [23:0] r_pos;
	logic        r_pv;
	logic [7:0]  count;
	logic [7:0]  seen_inc;
	logic [7:0]  sum_add;

	assign fire     = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_BYTE_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	assign count    = length_q - MIN_LENGTH;
	assign seen_inc = seen_q + 8'd1;
	assign sum_add  = sum_q + byte_s1;

	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		src_d    = src_q;
		dst_d    = dst_q;
		cmd_d    = cmd_q;
		last3_d  = last3_q;
		res      = 1'b0;
		r_kind   = KIND_PAYLOAD;
		r_pay    = '0;
		r_src    = '0;
		r_dst    = '0;
		r_cmd    = '0;
		r_cnt    = '0;
		r_status = STATUS_OK;
		r_pos    = '0;
		r_pv     = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == sync_q) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (byte_s1 < MIN_LENGTH) begin
					res      = 1'b1;
					r_kind   = KIND_SUMMARY;
					r_status = STATUS_LEN_ERR;
					phase_d  = PH_HUNT;
				end else begin
					length_d = byte_s1;
					sum_d    = byte_s1;
					phase_d  = PH_SRC;
				end
			end
			PH_SRC: begin
				src_d   = byte_s1;
				sum_d   = sum_add;
				phase_d = PH_DST;
			end
			PH_DST: begin
				dst_d   = byte_s1;
				sum_d   = sum_add;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				sum_d   = sum_add;
				seen_d  = '0;
				phase_d = (length_q == MIN_LENGTH) ? PH_CKS : PH_PAY;
			end
			PH_PAY: begin
				sum_d   = sum_add;
				last3_d = {last3_q[15:0], byte_s1};
				seen_d  = seen_inc;
				if (seen_inc >= count) begin
					phase_d = PH_CKS;
				end
				res   = 1'b1;
				r_pay = byte_s1;
			end
			PH_CKS: begin
				res      = 1'b1;
				r_kind   = KIND_SUMMARY;
				r_src    = src_q;
				r_dst    = dst_q;
				r_cmd    = cmd_q;
				r_cnt    = count;
				r_pv     = (count == MIN_LENGTH);
				r_pos    = r_pv ? last3_q : '0;
				r_status = ((8'd0 - sum_q) == byte_s1) ? STATUS_OK : STATUS_MISMATCH;
				phase_d  = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		// every return to hunting clears the frame
		if (phase_d == PH_HUNT || (phase_q == PH_HUNT && phase_d == PH_LEN)) begin
			length_d = '0;
			seen_d   = '0;
			sum_d    = '0;
			src_d    = '0;
			dst_d    = '0;
			cmd_d    = '0;
			last3_d  = '0;
		end
	end

	// frame state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			length_q       <= '0;
			seen_q         <= '0;
			sum_q          <= '0;
			src_q          <= '0;
			dst_q          <= '0;
			cmd_q          <= '0;
			last3_q        <= '0;
			out_valid      <= 1'b0;
			kind           <= KIND_PAYLOAD;
			payload_byte   <= '0;
			source_id      <= '0;
			dest_id        <= '0;
			command_code   <= '0;
			payload_count  <= '0;
			status         <= STATUS_OK;
			position       <= '0;
			position_valid <= 1'b0;
		end else begin
			if (fire) begin
				phase_q  <= phase_d;
				length_q <= length_d;
				seen_q   <= seen_d;
				sum_q    <= sum_d;
				src_q    <= src_d;
				dst_q    <= dst_d;
				cmd_q    <= cmd_d;
				last3_q  <= last3_d;
			end
			if (fire && res) begin
				out_valid      <= 1'b1;
				kind           <= r_kind;
				payload_byte   <= r_pay;
				source_id      <= r_src;
				dest_id        <= r_dst;
				command_code   <= r_cmd;
				payload_count  <= r_cnt;
				status         <= r_status;
				position       <= r_pos;
				position_valid <= r_pv;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* tb/aux_frame_parser_checker_test.sv */
// testbench for the aux frame parser: directed frames, then random byte streams checked by a frame predictor
`timescale 1ns / 1ps

module aux_frame_parser_checker_test;
	import afpc_pkg::*;

	typedef enum logic [2:0] {
		HUNT, GET_LEN, GET_SRC, GET_DST, GET_CMD, GET_PAYLOAD, GET_CHECKSUM
	} parse_phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
		logic [7:0]  command_code;
		logic [7:0]  payload_count;
		logic [1:0]  status;
		logic [23:0] position;
		logic        position_valid;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [7:0]  source_id;
	logic [7:0]  dest_id;
	logic [7:0]  command_code;
	logic [7:0]  payload_count;
	logic [1:0]  status;
	logic [23:0] position;
	logic        position_valid;

	aux_frame_parser_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.source_id(source_id),
		.dest_id(dest_id),
		.command_code(command_code),
		.payload_count(payload_count),
		.status(status),
		.position(position),
		.position_valid(position_valid)
	);

	// frame predictor state
	parse_phase_t p_phase;
	logic [7:0]   p_sync;
	logic [7:0]   p_len;
	logic [7:0]   p_count;
	logic [7:0]   p_sum;
	logic [7:0]   p_src;
	logic [7:0]   p_dst;
	logic [7:0]   p_cmd;
	logic [23:0]  p_tail;

	frame_result_t frame_results[$];
	stim_row_t     directed_rows[$];
	frame_result_t want;
	frame_result_t got;
	int unsigned   busy_bytes;
	int unsigned   mismatches;
	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic frame_result_t mk_summary(input logic [7:0] src, input logic [7:0] dst,
			input logic [7:0] cmd, input logic [7:0] count, input logic [1:0] st,
			input logic [23:0] pos, input logic pv);
		frame_result_t r;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.source_id = src;
		r.dest_id = dst;
		r.command_code = cmd;
		r.payload_count = count;
		r.status = st;
		r.position = pos;
		r.position_valid = pv;
		return r;
	endfunction

	function automatic frame_result_t mk_payload(input logic [7:0] b);
		frame_result_t r;
		r = '0;
		r.kind = KIND_PAYLOAD;
		r.payload_byte = b;
		return r;
	endfunction

	function automatic void clear_frame();
		p_phase = HUNT;
		p_len = '0;
		p_count = '0;
		p_sum = '0;
		p_src = '0;
		p_dst = '0;
		p_cmd = '0;
		p_tail = '0;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
		logic [7:0] count;
		logic       pv;
		r = '0;
		parse_byte = 1'b0;
		if (p_phase != HUNT || b == p_sync)
			busy_bytes++;
		case (p_phase)
			HUNT: begin
				if (b == p_sync) begin
					clear_frame();
					p_phase = GET_LEN;
				end
			end
			GET_LEN: begin
				if (b < MIN_LENGTH) begin
					r = mk_summary('0, '0, '0, '0, STATUS_LEN_ERR, '0, 1'b0);
					parse_byte = 1'b1;
					clear_frame();
				end else begin
					p_len = b;
					p_sum = b;
					p_phase = GET_SRC;
				end
			end
			GET_SRC: begin
				p_src = b;
				p_sum += b;
				p_phase = GET_DST;
			end
			GET_DST: begin
				p_dst = b;
				p_sum += b;
				p_phase = GET_CMD;
			end
			GET_CMD: begin
				p_cmd = b;
				p_sum += b;
				p_count = '0;
				p_phase = (p_len == MIN_LENGTH) ? GET_CHECKSUM : GET_PAYLOAD;
			end
			GET_PAYLOAD: begin
				p_sum += b;
				p_tail = {p_tail[15:0], b};
				p_count++;
				if (p_count >= p_len - MIN_LENGTH)
					p_phase = GET_CHECKSUM;
				r = mk_payload(b);
				parse_byte = 1'b1;
			end
			GET_CHECKSUM: begin
				count = p_len - MIN_LENGTH;
				pv = (count == 8'd3);
				r = mk_summary(p_src, p_dst, p_cmd, count,
					((8'h00 - p_sum) == b) ? STATUS_OK : STATUS_MISMATCH,
					pv ? p_tail : 24'd0, pv);
				parse_byte = 1'b1;
				clear_frame();
			end
			default: clear_frame();
		endcase
	endfunction

	// drive one request, hold it until accepted, then predict
	task automatic push_byte(input logic [7:0] b, input logic use_typed,
			input frame_result_t typed_res);
		frame_result_t r;
		bit            produced;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (!in_ready);
		produced = parse_byte(b, r);
		if (use_typed)
			frame_results.push_back(typed_res);
		else if (produced)
			frame_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		while (p_phase != HUNT)
			push_byte(8'($urandom), 1'b0, '0);
		in_valid = 1'b0;
		while (frame_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		p_sync = v;
	endtask

	task automatic send_frame();
		int unsigned pick;
		int unsigned len;
		logic [7:0]  sum;
		logic [7:0]  v;
		pick = $urandom_range(99);
		if (pick < 6)
			len = $urandom_range(2);
		else if (pick < 9)
			len = $urandom_range(255, 64);
		else if (pick < 30)
			len = 6;
		else
			len = $urandom_range(10, 3);
		push_byte(p_sync, 1'b0, '0);
		push_byte(8'(len), 1'b0, '0);
		if (len >= 3) begin
			sum = 8'(len);
			for (int i = 0; i < len; i++) begin
				v = 8'($urandom);
				sum += v;
				push_byte(v, 1'b0, '0);
			end
			if ($urandom_range(99) < 80)
				push_byte(8'h00 - sum, 1'b0, '0);
			else
				push_byte(8'($urandom), 1'b0, '0);
		end
	endtask

	task automatic run_random(input int unsigned target);
		while (busy_bytes < target) begin
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(4, 1)) push_byte(8'($urandom), 1'b0, '0);
			send_frame();
		end
	endtask

	task automatic check_field(input string name, input int unsigned expv,
			input int unsigned actv);
		if (expv != actv) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {kind, payload_byte, source_id, dest_id, command_code, payload_count,
				status, position, position_valid};
			if (frame_results.size() == 0) begin
				$error("result with no request pending: 0x%0h", got);
				mismatches++;
			end else begin
				want = frame_results.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("payload_byte", want.payload_byte, got.payload_byte);
				check_field("source_id", want.source_id, got.source_id);
				check_field("dest_id", want.dest_id, got.dest_id);
				check_field("command_code", want.command_code, got.command_code);
				check_field("payload_count", want.payload_count, got.payload_count);
				check_field("status", want.status, got.status);
				check_field("position", want.position, got.position);
				check_field("position_valid", want.position_valid, got.position_valid);
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		busy_bytes = 0;
		mismatches = 0;
		send_idle_pct = 23;
		recv_idle_pct = 85;
		p_sync = SYNC_BYTE_RESET;
		clear_frame();

		directed_rows = '{
			'{8'h00, 1'b0, '0},
			'{8'hff, 1'b0, '0},
			'{8'h3b, 1'b0, '0},
			'{8'h02, 1'b1, mk_summary('0, '0, '0, '0, STATUS_LEN_ERR, '0, 1'b0)},
			'{8'h3b, 1'b0, '0},
			'{8'h00, 1'b1, mk_summary('0, '0, '0, '0, STATUS_LEN_ERR, '0, 1'b0)},
			'{8'h3b, 1'b0, '0},
			'{8'h03, 1'b0, '0},
			'{8'hff, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'haa, 1'b0, '0},
			'{8'h54, 1'b1, mk_summary(8'hff, 8'h00, 8'haa, 8'd0, STATUS_OK, '0, 1'b0)},
			'{8'h3b, 1'b0, '0},
			'{8'h06, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'h02, 1'b0, '0},
			'{8'h03, 1'b0, '0},
			'{8'hff, 1'b1, mk_payload(8'hff)},
			'{8'h00, 1'b1, mk_payload(8'h00)},
			'{8'h80, 1'b0, '0},
			'{8'h74, 1'b1, mk_summary(8'h01, 8'h02, 8'h03, 8'd3, STATUS_MISMATCH,
				24'hff0080, 1'b1)}
		};

		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (directed_rows[i])
			push_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

		write_sync(8'h00);
		run_random(busy_bytes + 230);

		send_idle_pct = 85;
		recv_idle_pct = 23;
		write_sync(8'hff);
		run_random(busy_bytes + 230);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_sync(8'($urandom));
		run_random(busy_bytes + 230);

		in_valid = 1'b0;
		while (frame_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && frame_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* aux_frame_parser_checker.f */
rtl/afpc_pkg.sv
rtl/aux_frame_parser_checker.sv
tb/aux_frame_parser_checker_test.sv
